@@ hdl/infix_to_postfix_converter_macros.svh @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// same-cycle implication
`define IPC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ipc_pkg.sv @@
// ----------------------------------------------------------------------------
// ipc_pkg
// Types, character codes and classification functions of the converter.
// ----------------------------------------------------------------------------
package ipc_pkg;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam int STATUS_OVERFLOW  = 0;
  localparam int STATUS_UNMATCHED = 1;

  // command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [2:0] {
    CMD_EMIT,
    CMD_OPER,
    CMD_OPEN,
    CMD_CLOSE,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  ch;
    logic [1:0]  prec;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_DECIDE
  } back_state_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    if (c == CH_CARET) p = 2'd3;
    return p;
  endfunction

  function automatic logic is_open(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE);
  endfunction

  function automatic logic is_close(input logic [7:0] c);
    return (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

@@ hdl/ipc_front.sv @@
// ----------------------------------------------------------------------------
// ipc_front
// Accepts input characters, classifies them and hands commands to the queue.
// ----------------------------------------------------------------------------
module ipc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] symbol
  input  logic              s_tlast,   // end_of_expression
  input  ipc_pkg::q_stat_t  q_stat,
  output logic              q_wr,
  output ipc_pkg::cmd_t     q_wr_cmd
);

  logic          hold_valid;
  ipc_pkg::cmd_t hold_cmd;
  ipc_pkg::cmd_t cls;
  logic          keep;

  always_comb begin
    keep      = 1'b1;
    cls.kind  = ipc_pkg::CMD_EMIT;
    cls.ch    = s_tdata;
    cls.prec  = ipc_pkg::prec_of(s_tdata);
    if (s_tlast) begin
      cls.kind = ipc_pkg::CMD_END;
    end else if (s_tdata == ipc_pkg::CH_SPACE || s_tdata == ipc_pkg::CH_COMMA) begin
      cls.ch = ipc_pkg::CH_SPACE;
    end else if (ipc_pkg::is_alnum(s_tdata)) begin
      cls.kind = ipc_pkg::CMD_EMIT;
    end else if (cls.prec != 2'd0) begin
      cls.kind = ipc_pkg::CMD_OPER;
    end else if (ipc_pkg::is_open(s_tdata)) begin
      cls.kind = ipc_pkg::CMD_OPEN;
    end else if (ipc_pkg::is_close(s_tdata)) begin
      cls.kind = ipc_pkg::CMD_CLOSE;
    end else begin
      keep = 1'b0;
    end
  end

  // the holding register empties into the queue whenever the queue has room
  assign s_tready = !hold_valid || !q_stat.full;
  assign q_wr     = hold_valid;
  assign q_wr_cmd = hold_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      hold_cmd <= cls;
    end
  end

endmodule

@@ hdl/ipc_fifo.sv @@
// ----------------------------------------------------------------------------
// ipc_fifo
// Short command queue decoupling the classifier from the stack engine.
// ----------------------------------------------------------------------------
module ipc_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  ipc_pkg::cmd_t     wr_cmd,
  input  logic              rd,
  output ipc_pkg::cmd_t     rd_cmd,
  output ipc_pkg::q_stat_t  stat
);

  ipc_pkg::cmd_t                 slots [ipc_pkg::Q_DEPTH];
  logic [ipc_pkg::Q_AW-1:0]      wr_ptr;
  logic [ipc_pkg::Q_AW-1:0]      rd_ptr;
  logic [ipc_pkg::Q_AW:0]        fill;

  assign stat.full  = (fill == (ipc_pkg::Q_AW + 1)'(ipc_pkg::Q_DEPTH));
  assign stat.empty = (fill == '0);
  assign rd_cmd     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      if (wr && !rd) begin
        fill <= fill + 1'b1;
      end else if (rd && !wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

endmodule

@@ hdl/ipc_back.sv @@
// ----------------------------------------------------------------------------
// ipc_back
// Stack engine: runs queued commands against the operator stack and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module ipc_back #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  ipc_pkg::q_stat_t  q_stat,
  output logic              q_rd,
  input  ipc_pkg::cmd_t     q_rd_cmd,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // [7:0] out_char, [9:8] status, rest zero
  output logic              m_tuser,   // char_valid
  output logic              m_tlast    // last_of_expression
);

  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [7:0]             stack_mem [STACK_DEPTH];
  logic [7:0]             rd_q;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_m1;
  logic [IW-1:0]          rd_idx;
  logic [1:0]             err;
  ipc_pkg::cmd_t          cur;
  ipc_pkg::back_state_t   state, state_next;

  logic       out_free;
  logic       out_load;
  logic [7:0] out_ch;
  logic       out_cv;
  logic       out_last;
  logic [1:0] out_st;
  logic       push_req;
  logic       push_en;
  logic [7:0] push_ch;
  logic       pop_en;
  logic       set_ovf;
  logic       set_unm;
  logic       err_clr;
  logic       done;
  logic       top_pops;

  assign out_free = !m_tvalid || m_tready;
  assign count_m1 = count - CW'(1);
  assign rd_idx   = (count == '0) ? '0 : count_m1[IW-1:0];
  assign push_en  = push_req && (count < CW'(STACK_DEPTH));
  assign set_ovf  = push_req && !(count < CW'(STACK_DEPTH));
  assign top_pops = (count != '0) && (ipc_pkg::prec_of(rd_q) != 2'd0) &&
                    (ipc_pkg::prec_of(rd_q) >= cur.prec);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ipc_pkg::ST_IDLE: begin
        if (q_rd && q_rd_cmd.kind != ipc_pkg::CMD_EMIT &&
            q_rd_cmd.kind != ipc_pkg::CMD_OPEN) begin
          state_next = ipc_pkg::ST_WAIT;
        end
      end
      ipc_pkg::ST_WAIT: begin
        state_next = ipc_pkg::ST_DECIDE;
      end
      ipc_pkg::ST_DECIDE: begin
        if (done) begin
          state_next = ipc_pkg::ST_IDLE;
        end else if (pop_en) begin
          // new top comes through the registered read in ST_WAIT
          state_next = ipc_pkg::ST_WAIT;
        end
      end
      default: begin
        state_next = ipc_pkg::ST_IDLE;
      end
    endcase
  end

  // actions
  always_comb begin
    q_rd     = 1'b0;
    out_load = 1'b0;
    out_ch   = rd_q;
    out_cv   = 1'b1;
    out_last = 1'b0;
    out_st   = 2'd0;
    push_req = 1'b0;
    push_ch  = cur.ch;
    pop_en   = 1'b0;
    set_unm  = 1'b0;
    err_clr  = 1'b0;
    done     = 1'b0;
    case (state)
      ipc_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          if (q_rd_cmd.kind == ipc_pkg::CMD_EMIT) begin
            if (out_free) begin
              q_rd     = 1'b1;
              out_load = 1'b1;
              out_ch   = q_rd_cmd.ch;
            end
          end else if (q_rd_cmd.kind == ipc_pkg::CMD_OPEN) begin
            q_rd     = 1'b1;
            push_req = 1'b1;
            push_ch  = q_rd_cmd.ch;
          end else begin
            q_rd = 1'b1;
          end
        end
      end
      ipc_pkg::ST_DECIDE: begin
        case (cur.kind)
          ipc_pkg::CMD_OPER: begin
            if (top_pops) begin
              if (out_free) begin
                out_load = 1'b1;
                pop_en   = 1'b1;
              end
            end else begin
              push_req = 1'b1;
              done     = 1'b1;
            end
          end
          ipc_pkg::CMD_CLOSE: begin
            if (count == '0) begin
              set_unm = 1'b1;
              done    = 1'b1;
            end else if (ipc_pkg::is_open(rd_q)) begin
              pop_en = 1'b1;
              done   = 1'b1;
            end else if (out_free) begin
              out_load = 1'b1;
              pop_en   = 1'b1;
            end
          end
          ipc_pkg::CMD_END: begin
            if (out_free) begin
              out_load = 1'b1;
              if (count == '0) begin
                out_ch   = 8'd0;
                out_cv   = 1'b0;
                out_last = 1'b1;
                out_st   = err;
                err_clr  = 1'b1;
                done     = 1'b1;
              end else begin
                pop_en = 1'b1;
                if (count == CW'(1)) begin
                  out_last = 1'b1;
                  out_st   = err;
                  err_clr  = 1'b1;
                  done     = 1'b1;
                end
              end
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipc_pkg::ST_IDLE;
      count <= '0;
      err   <= 2'd0;
    end else begin
      state <= state_next;
      if (push_en) begin
        count <= count + CW'(1);
      end else if (pop_en) begin
        count <= count_m1;
      end
      if (err_clr) begin
        err <= 2'd0;
      end else begin
        err[ipc_pkg::STATUS_OVERFLOW]  <= err[ipc_pkg::STATUS_OVERFLOW] | set_ovf;
        err[ipc_pkg::STATUS_UNMATCHED] <= err[ipc_pkg::STATUS_UNMATCHED] | set_unm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ipc_pkg::ST_IDLE && q_rd) begin
      cur <= q_rd_cmd;
    end
  end

  // operator stack, top entry read through a register
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[count[IW-1:0]] <= push_ch;
    end
    rd_q <= stack_mem[rd_idx];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'b0, out_st, out_ch};
      m_tuser <= out_cv;
      m_tlast <= out_last;
    end
  end

endmodule

@@ hdl/infix_to_postfix_converter.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an ASCII infix stream into postfix.
// ----------------------------------------------------------------------------
// The front takes one character per cycle while its four-entry command queue
// has room; characters that mean nothing are dropped there at no further
// cost. The stack engine behind it emits a letter, digit, space or comma and
// pushes an opening bracket straight from its idle state. An operator, closing
// bracket or end of expression passes through ST_WAIT before its first look at
// the stack top in ST_DECIDE, and back through ST_WAIT for each further look
// after a pop, since every change of the stack pointer waits for the
// registered read of the operator stack memory. An end of expression always
// delivers at least one result, the last one carrying tlast and the sticky
// status (bit 0 a dropped push on a full stack, bit 1 a closing bracket with
// no match). Result backpressure stalls the engine first, and the input only
// once the queue and the front's holding register have filled up.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic        s_tlast,   // end_of_expression
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_char, [9:8] status, rest zero
  output logic        m_tuser,   // char_valid
  output logic        m_tlast    // last_of_expression
);

  `include "infix_to_postfix_converter_macros.svh"

  logic              q_wr;
  ipc_pkg::cmd_t     q_wr_cmd;
  logic              q_rd;
  ipc_pkg::cmd_t     q_rd_cmd;
  ipc_pkg::q_stat_t  q_stat;

  ipc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_stat   (q_stat),
    .q_wr     (q_wr),
    .q_wr_cmd (q_wr_cmd)
  );

  ipc_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr && !q_stat.full),
    .wr_cmd (q_wr_cmd),
    .rd     (q_rd),
    .rd_cmd (q_rd_cmd),
    .stat   (q_stat)
  );

  ipc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .q_rd     (q_rd),
    .q_rd_cmd (q_rd_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `IPC_ASSERT_IMPLY(a_rd_not_empty, q_rd, !q_stat.empty, "queue read while empty")
  `IPC_ASSERT_NEXT(a_wr_fills, q_wr && !q_stat.full, !q_stat.empty, "queue lost a write")
  `IPC_ASSERT_IMPLY(a_status_final, m_tvalid && (m_tdata[9:8] != 2'd0), m_tlast,
    "status on a non-final result")
  `IPC_ASSERT_IMPLY(a_marker_final, m_tvalid && !m_tuser, m_tlast && (m_tdata[7:0] == 8'd0),
    "empty marker not final")

endmodule

@@ dv/postfix_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// postfix_checker
// Watches both stream channels of the infix to postfix converter, keeps its
// own operator stack to work out the postfix characters each accepted symbol
// should produce, and compares every returned transaction field by field.
// ----------------------------------------------------------------------------
module postfix_checker #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending,
  output int          active_items,
  output int          results_checked,
  output int          exprs_done,
  output int          flagged_exprs
);

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       last;
    logic [1:0] status;
  } postfix_char_t;

  logic [7:0]    op_stack [STACK_DEPTH];
  int            depth;
  logic [1:0]    sticky;
  postfix_char_t expected_postfix [$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    active_items    = 0;
    results_checked = 0;
    exprs_done      = 0;
    flagged_exprs   = 0;
    depth           = 0;
    sticky          = 2'b00;
  end

  function automatic int rank(input logic [7:0] c);
    case (c)
      ipc_pkg::CH_PLUS, ipc_pkg::CH_MINUS: return 1;
      ipc_pkg::CH_STAR, ipc_pkg::CH_SLASH: return 2;
      ipc_pkg::CH_CARET:                   return 3;
      default:                             return 0;
    endcase
  endfunction

  function automatic logic opens(input logic [7:0] c);
    return (c == ipc_pkg::CH_LPAREN) || (c == ipc_pkg::CH_LBRACK) ||
           (c == ipc_pkg::CH_LBRACE);
  endfunction

  function automatic logic closes(input logic [7:0] c);
    return (c == ipc_pkg::CH_RPAREN) || (c == ipc_pkg::CH_RBRACK) ||
           (c == ipc_pkg::CH_RBRACE);
  endfunction

  function automatic logic operand_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void expect_char(input logic [7:0] c, input logic v, input logic l,
                                      input logic [1:0] st);
    postfix_char_t item;
    item.out_char   = c;
    item.char_valid = v;
    item.last       = l;
    item.status     = st;
    expected_postfix.push_back(item);
  endfunction

  function automatic void stack_push(input logic [7:0] c);
    if (depth >= STACK_DEPTH) begin
      sticky[ipc_pkg::STATUS_OVERFLOW] = 1'b1;
    end else begin
      op_stack[depth] = c;
      depth++;
    end
  endfunction

  function automatic void convert_symbol(input logic [7:0] sym, input logic eoe);
    logic matched;
    matched = 1'b0;
    if (eoe) begin
      active_items++;
      exprs_done++;
      if (sticky != 2'b00) flagged_exprs++;
      if (depth == 0) begin
        // empty stack still closes the expression with a marker
        expect_char(8'h00, 1'b0, 1'b1, sticky);
      end else begin
        while (depth > 0) begin
          depth--;
          expect_char(op_stack[depth], 1'b1, depth == 0, (depth == 0) ? sticky : 2'b00);
        end
      end
      sticky = 2'b00;
    end else if (sym == ipc_pkg::CH_SPACE || sym == ipc_pkg::CH_COMMA) begin
      active_items++;
      expect_char(ipc_pkg::CH_SPACE, 1'b1, 1'b0, 2'b00);
    end else if (operand_char(sym)) begin
      active_items++;
      expect_char(sym, 1'b1, 1'b0, 2'b00);
    end else if (rank(sym) != 0) begin
      active_items++;
      // brackets rank zero, so popping stops below them
      while (depth > 0 && rank(op_stack[depth - 1]) >= rank(sym)) begin
        depth--;
        expect_char(op_stack[depth], 1'b1, 1'b0, 2'b00);
      end
      stack_push(sym);
    end else if (opens(sym)) begin
      active_items++;
      stack_push(sym);
    end else if (closes(sym)) begin
      active_items++;
      while (depth > 0 && !matched) begin
        depth--;
        if (opens(op_stack[depth])) matched = 1'b1;
        else expect_char(op_stack[depth], 1'b1, 1'b0, 2'b00);
      end
      if (!matched) sticky[ipc_pkg::STATUS_UNMATCHED] = 1'b1;
    end
  endfunction

  always @(posedge clk) begin : monitor
    postfix_char_t want;
    if (rst) begin
      depth  = 0;
      sticky = 2'b00;
      expected_postfix.delete();
    end else begin
      if (s_tvalid && s_tready) convert_symbol(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        results_checked++;
        if (expected_postfix.size() == 0) begin
          $error("unexpected transaction: out_char=%h char_valid=%b last=%b status=%b",
                 m_tdata[7:0], m_tuser, m_tlast, m_tdata[9:8]);
          fail_count++;
        end else begin
          want = expected_postfix.pop_front();
          if (m_tdata[7:0] !== want.out_char) begin
            $error("out_char: expected %h, got %h", want.out_char, m_tdata[7:0]);
            fail_count++;
          end
          if (m_tuser !== want.char_valid) begin
            $error("char_valid: expected %b, got %b", want.char_valid, m_tuser);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last_of_expression: expected %b, got %b", want.last, m_tlast);
            fail_count++;
          end
          if (m_tdata[9:8] !== want.status) begin
            $error("status: expected %b, got %b", want.status, m_tdata[9:8]);
            fail_count++;
          end
          if (m_tdata[15:10] !== 6'd0) begin
            $error("tdata padding: expected %h, got %h", 6'd0, m_tdata[15:10]);
            fail_count++;
          end
        end
      end
    end
    pending = expected_postfix.size();
  end

endmodule

@@ dv/tb_infix_to_postfix_converter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter
// Drives infix character streams into the converter: directed cases for
// every operator, bracket kind and error flag, mixed with random, broken and
// noise expressions under changing backpressure.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter;

  localparam int STACK_DEPTH  = 32;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] symbol
  logic        s_tlast;    // end_of_expression
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;    // [7:0] out_char, [9:8] status, rest zero
  logic        m_tuser;    // char_valid
  logic        m_tlast;    // last_of_expression

  int fail_count;
  int pending;
  int active_items;
  int results_checked;
  int exprs_done;
  int flagged_exprs;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_request;
  int hold_left;
  int cycle_count;

  infix_to_postfix_converter #(
    .STACK_DEPTH (STACK_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  postfix_checker #(
    .STACK_DEPTH (STACK_DEPTH)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tlast         (m_tlast),
    .fail_count      (fail_count),
    .pending         (pending),
    .active_items    (active_items),
    .results_checked (results_checked),
    .exprs_done      (exprs_done),
    .flagged_exprs   (flagged_exprs)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [7:0] random_operator();
    case ($urandom_range(4))
      0:       return ipc_pkg::CH_PLUS;
      1:       return ipc_pkg::CH_MINUS;
      2:       return ipc_pkg::CH_STAR;
      3:       return ipc_pkg::CH_SLASH;
      default: return ipc_pkg::CH_CARET;
    endcase
  endfunction

  function automatic logic [7:0] open_bracket(input int kind);
    case (kind)
      0:       return ipc_pkg::CH_LPAREN;
      1:       return ipc_pkg::CH_LBRACK;
      default: return ipc_pkg::CH_LBRACE;
    endcase
  endfunction

  function automatic logic [7:0] close_bracket(input int kind);
    case (kind)
      0:       return ipc_pkg::CH_RPAREN;
      1:       return ipc_pkg::CH_RBRACK;
      default: return ipc_pkg::CH_RBRACE;
    endcase
  endfunction

  function automatic logic [7:0] random_operand();
    case ($urandom_range(2))
      0:       return 8'(8'h30 + $urandom_range(9));
      1:       return 8'(8'h41 + $urandom_range(25));
      default: return 8'(8'h61 + $urandom_range(25));
    endcase
  endfunction

  task automatic send(input logic [7:0] sym, input logic eoe);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tlast  <= eoe;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop offering, then wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // operands and operators in turn, with nested brackets of mixed kinds;
  // a broken one loses closers or gains a stray one
  task automatic send_expression(input bit broken);
    logic [7:0] closers [$];
    int         terms;
    int         kind;
    int         t;
    terms = $urandom_range(1, 5);
    for (t = 0; t < terms; t++) begin
      if (t > 0) begin
        if ($urandom_range(4) == 0) begin
          send($urandom_range(1) ? ipc_pkg::CH_SPACE : ipc_pkg::CH_COMMA, 1'b0);
        end
        send(random_operator(), 1'b0);
      end
      while ($urandom_range(3) == 0 && closers.size() < 8) begin
        kind = $urandom_range(2);
        send(open_bracket(kind), 1'b0);
        closers.push_back(close_bracket(kind));
      end
      repeat ($urandom_range(1, 2)) send(random_operand(), 1'b0);
      while (closers.size() > 0 && $urandom_range(1) == 0) send(closers.pop_back(), 1'b0);
    end
    while (closers.size() > 0) begin
      if (broken && $urandom_range(1) == 0) void'(closers.pop_back());
      else send(closers.pop_back(), 1'b0);
    end
    if (broken && $urandom_range(1) == 0) send(close_bracket($urandom_range(2)), 1'b0);
    send(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(3, 8)) send(8'($urandom_range(255)), 1'b0);
    send(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic run_random(input int target);
    int pick;
    while (active_items < target) begin
      pick = $urandom_range(99);
      if (pick < 75) send_expression(1'b0);
      else if (pick < 90) send_expression(1'b1);
      else send_noise();
    end
  endtask

  task automatic send_string(input string text);
    int i;
    for (i = 0; i < text.len(); i++) send(text[i], 1'b0);
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    s_tlast      = 1'b0;
    m_tready     = 1'b0;
    tx_idle_pct  = 15;
    rx_idle_pct  = 53;
    hold_request = 0;
    hold_left    = 0;
    cycle_count  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // byte extremes are ignored; an end on an empty stack gives the marker
    send(8'h00, 1'b0);
    send(8'hFF, 1'b1);
    // all operators, braces around a sub-expression
    send_string("a+{b*c}^d-e/f");
    send(8'h00, 1'b1);
    // unmatched closer first, a bracket closed by another kind, leftover opener
    send_string(") [x, (y]^");
    send(ipc_pkg::CH_CARET, 1'b1);

    run_random(70);

    // deep nesting past the stack size, then a full-depth flush
    wait_drained();
    repeat (34) send(open_bracket($urandom_range(2)), 1'b0);
    send(ipc_pkg::CH_STAR, 1'b0);
    send(8'($urandom_range(255)), 1'b1);

    tx_idle_pct = 53;
    rx_idle_pct = 15;
    run_random(130);

    // long receiver hold-off while operands keep coming, to fill the block
    wait_drained();
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_request = 200;
    repeat (30) send(random_operand(), 1'b0);
    send(8'h00, 1'b1);
    run_random(190);

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d symbol transactions, %0d postfix results in %0d expressions",
             active_items, results_checked, exprs_done);
    $display("%0d expressions closed with overflow or unmatched-bracket status",
             flagged_exprs);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
